// ===== sv/mhsq_pkg.sv =====
// shared constants and helpers for the single query attention block
package mhsq_pkg;
  localparam int unsigned DimMaxDefault    = 64;
  localparam int unsigned BlocksMaxDefault = 16;
  localparam int unsigned HeadsMaxDefault  = 8;
  localparam int unsigned Log2eQ16         = 94548;

  localparam logic [2:0] RegDim   = 3'd0;
  localparam logic [2:0] RegHeads = 3'd1;
  localparam logic [2:0] RegBlks  = 3'd2;
  localparam logic [2:0] RegQuery = 3'd3;
  localparam logic [2:0] RegScale = 3'd4;

  function automatic logic [16:0] pow2_tab(input logic [4:0] k);
    logic [16:0] t;
    unique case (k)
      5'd0:  t = 17'd65536;
      5'd1:  t = 17'd62757;
      5'd2:  t = 17'd60097;
      5'd3:  t = 17'd57549;
      5'd4:  t = 17'd55109;
      5'd5:  t = 17'd52773;
      5'd6:  t = 17'd50535;
      5'd7:  t = 17'd48392;
      5'd8:  t = 17'd46341;
      5'd9:  t = 17'd44376;
      5'd10: t = 17'd42495;
      5'd11: t = 17'd40693;
      5'd12: t = 17'd38968;
      5'd13: t = 17'd37316;
      5'd14: t = 17'd35734;
      5'd15: t = 17'd34218;
      default: t = 17'd32768;
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [31:0] den;
  } div_req_t;
endpackage

// ===== sv/multihead_attention_single_query.sv =====
// top level of the single query multi head attention block
// Elements are taken one per cycle while a job loads. After the last element the head slice
// width is found by repeated subtraction, then a sequencer runs one shared multiply-accumulate
// unit: for each head, per block the dot product and scaling, then per block the exp, then per
// block the weight (a serial restoring divide); then per block and element the weighted sums,
// and then each output element. A job with a bad head count skips these steps and emits one
// element per cycle when the output is not stalled. The input is not ready meanwhile. Vector,
// score and accumulator stores are memories.
module multihead_attention_single_query
  import mhsq_pkg::*;
#(
  parameter int unsigned DIM_MAX    = DimMaxDefault,
  parameter int unsigned BLOCKS_MAX = BlocksMaxDefault,
  parameter int unsigned HEADS_MAX  = HeadsMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // elem_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_value
  output logic        m_axis_tlast,   // out_last
  output logic        m_axis_tuser    // error
);
  localparam int unsigned VecDepth = DIM_MAX * BLOCKS_MAX;
  localparam int unsigned VaW = $clog2(VecDepth + 1);
  localparam int unsigned DW  = $clog2(DIM_MAX + 1);
  localparam int unsigned BW  = $clog2(BLOCKS_MAX + 1);
  localparam int unsigned HW  = $clog2(HEADS_MAX + 1);
  localparam int unsigned SD  = BLOCKS_MAX * HEADS_MAX;
  localparam int unsigned SaW = (SD > 1) ? $clog2(SD) : 1;
  localparam int unsigned AaW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int unsigned ViW = (VecDepth > 1) ? $clog2(VecDepth) : 1;

  typedef enum logic [3:0] {
    S_LOAD, S_HDIV, S_DOT_A, S_DOT_B, S_SCALE, S_EXP_A, S_EXP_B, S_EXP_C, S_DIV_A, S_DIV_B,
    S_DIV_W, S_WS_A, S_WS_B, S_OUT_A, S_OUT_B, S_EMIT
  } state_e;

  state_e state_q;
  logic [6:0]  dim_r_q;
  logic [3:0]  heads_r_q;
  logic [4:0]  blks_r_q;
  logic [3:0]  query_r_q;
  logic [15:0] scale_r_q;

  logic signed [15:0] vec_mem [VecDepth];
  logic signed [31:0] score_mem [SD];
  logic signed [39:0] acc_mem [DIM_MAX];
  logic [31:0] hsum_q;

  logic [VaW-1:0] load_q;
  logic [DW-1:0]  dim_q, hd_q, k_q, kk_q, hk_q, hrem_q;
  logic [BW-1:0]  nb_q, b_q, q_q;
  logic [HW-1:0]  h_q, hn_q;
  logic           err_q;
  logic signed [47:0] dot_q;
  logic signed [31:0] mx_q;
  logic signed [15:0] va_q, vb_q;
  logic signed [31:0] sc_q;
  logic signed [39:0] ac_q;
  logic [31:0] ex_q;
  logic        ob_full_q;
  logic [15:0] ob_val_q;
  logic        ob_last_q, ob_err_q;

  // derived config for the clamp
  logic [DW-1:0] dim_c;
  logic [BW-1:0] nb_c;
  logic [VaW+DW-1:0] total_c;
  always_comb begin
    dim_c = (dim_r_q == 7'd0) ? DW'(1) :
            ({25'd0, dim_r_q} > DIM_MAX) ? DW'(DIM_MAX) : DW'(dim_r_q);
    nb_c  = (blks_r_q == 5'd0) ? BW'(1) :
            ({27'd0, blks_r_q} > BLOCKS_MAX) ? BW'(BLOCKS_MAX) : BW'(blks_r_q);
    total_c = (VaW+DW)'(dim_c) * (VaW+DW)'(nb_c);
  end

  // shared multiplier operands
  logic signed [47:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [64:0] mul_p;
  always_comb begin
    mul_a = 48'(va_q);
    mul_b = 17'(vb_q);
    unique case (state_q)
      S_SCALE: begin mul_a = dot_q; mul_b = {1'b0, scale_r_q}; end
      S_WS_B:  begin mul_a = 48'(sc_q); mul_b = 17'(va_q); end
      default: ;
    endcase
    mul_p = 65'(mul_a) * 65'(mul_b);
  end

  // exp of a non-negative q16 distance
  logic [63:0] x_u;
  logic [63:0] y_u;
  logic [16:0] ta, tb, m_v;
  logic [28:0] dr;
  logic [31:0] e_v;
  always_comb begin
    x_u = {32'd0, ex_q};
    y_u = (x_u * 64'(Log2eQ16)) >> 16;
    ta = pow2_tab({1'b0, y_u[15:12]});
    tb = pow2_tab({1'b0, y_u[15:12]} + 5'd1);
    dr = 29'(ta - tb) * 29'(y_u[11:0]);
    m_v = ta - 17'(dr >> 12);
    e_v = (y_u[63:16] > 48'd16) ? 32'd0 : 32'(m_v >> y_u[20:16]);
  end

  div_req_t dreq;
  logic dv_done;
  logic [47:0] dv_q;
  mhsq_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(dv_done), .quot_o(dv_q));

  logic signed [32:0] ex_diff;
  logic signed [64:0] sc_sh;
  logic signed [31:0] sc_sat;
  logic signed [40:0] rnd;
  logic [BW+DW-1:0] vi_b, vi_q;
  logic [BW+HW-1:0] si;
  always_comb begin
    ex_diff = 33'(mx_q) - 33'(sc_q);
    sc_sh = mul_p >>> 16;
    sc_sat = (sc_sh > 65'sd2147483647) ? 32'h7fffffff :
             (sc_sh < -65'sd2147483648) ? 32'h80000000 : sc_sh[31:0];
    rnd = (41'(ac_q) + 41'sd32768) >>> 16;
    vi_b = (BW+DW)'(b_q) * (BW+DW)'(dim_q) + (BW+DW)'(kk_q);
    vi_q = (BW+DW)'(q_q) * (BW+DW)'(dim_q) + (BW+DW)'(kk_q);
    si = (BW+HW)'(b_q) * (BW+HW)'(HEADS_MAX) + (BW+HW)'(h_q);
    dreq.start = (state_q == S_DIV_B);
    dreq.num = {sc_q, 16'd0};
    dreq.den = hsum_q;
  end

  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = ob_full_q;
  assign m_axis_tdata  = ob_val_q;
  assign m_axis_tlast  = ob_last_q;
  assign m_axis_tuser  = ob_err_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready && load_q < VaW'(VecDepth))
      vec_mem[ViW'(load_q)] <= s_axis_tdata;
    va_q <= vec_mem[ViW'(vi_b)];
    vb_q <= vec_mem[ViW'(vi_q)];
    sc_q <= score_mem[SaW'(si)];
    ac_q <= acc_mem[AaW'(k_q)];
    if (state_q == S_SCALE) score_mem[SaW'(si)] <= sc_sat;
    if (state_q == S_EXP_C) score_mem[SaW'(si)] <= e_v;
    if (state_q == S_DIV_W && dv_done) score_mem[SaW'(si)] <= dv_q[31:0];
    if (state_q == S_WS_B)
      acc_mem[AaW'(k_q)] <= ((b_q == '0) ? 40'sd0 : ac_q) + mul_p[39:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      dim_r_q <= 7'd64; heads_r_q <= 4'd1; blks_r_q <= 5'd16;
      query_r_q <= 4'd0; scale_r_q <= 16'd8192;
      load_q <= '0; dim_q <= '0; hd_q <= '0; k_q <= '0; kk_q <= '0;
      hk_q <= '0; hrem_q <= '0;
      nb_q <= '0; b_q <= '0; q_q <= '0; h_q <= '0; hn_q <= '0; err_q <= 1'b0;
      dot_q <= '0; mx_q <= '0; ex_q <= '0; hsum_q <= '0;
      ob_full_q <= 1'b0; ob_val_q <= '0; ob_last_q <= 1'b0; ob_err_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegDim:   dim_r_q   <= cfg_data_i[6:0];
          RegHeads: heads_r_q <= cfg_data_i[3:0];
          RegBlks:  blks_r_q  <= cfg_data_i[4:0];
          RegQuery: query_r_q <= cfg_data_i[3:0];
          RegScale: scale_r_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_EMIT && (!ob_full_q || m_axis_tready)) ob_full_q <= 1'b1;
      else if (m_axis_tready) ob_full_q <= 1'b0;
      unique case (state_q)
        S_LOAD: if (s_axis_tvalid) begin
          if ((VaW+DW)'(load_q) + 1 >= total_c) begin
            load_q <= '0;
            dim_q <= dim_c; nb_q <= nb_c;
            q_q <= ({1'b0, query_r_q} >= 5'(nb_c)) ? nb_c - 1'b1 : BW'(query_r_q);
            err_q <= (heads_r_q == 4'd0) || ({28'd0, heads_r_q} > HEADS_MAX);
            hn_q <= HW'(heads_r_q);
            hd_q <= '0; hrem_q <= dim_c;
            h_q <= '0; b_q <= '0; k_q <= '0;
            state_q <= S_HDIV;
          end else load_q <= load_q + 1'b1;
        end
        // slice width by repeated subtraction, leftover flags a bad head count
        S_HDIV: begin
          if (err_q || hrem_q < DW'(hn_q)) begin
            if (hrem_q != '0) err_q <= 1'b1;
            state_q <= S_DOT_A;
          end else begin
            hrem_q <= hrem_q - DW'(hn_q);
            hd_q <= hd_q + 1'b1;
          end
        end
        S_DOT_A: begin
          if (err_q) begin
            k_q <= '0; state_q <= S_EMIT;
          end else begin
            kk_q <= DW'(h_q) * hd_q; k_q <= '0; dot_q <= '0;
            if (b_q == '0) mx_q <= 32'sh80000000;
            state_q <= S_DOT_B;
          end
        end
        S_DOT_B: begin
          if (k_q != '0) dot_q <= dot_q + 48'(mul_p);
          if (k_q == hd_q) state_q <= S_SCALE;
          else begin kk_q <= kk_q + 1'b1; k_q <= k_q + 1'b1; end
        end
        S_SCALE: begin
          if (sc_sat > mx_q) mx_q <= sc_sat;
          if (b_q == nb_q - 1'b1) begin
            b_q <= '0; hsum_q <= '0; state_q <= S_EXP_A;
          end else begin b_q <= b_q + 1'b1; state_q <= S_DOT_A; end
        end
        S_EXP_A: state_q <= S_EXP_B;
        S_EXP_B: begin
          ex_q <= ex_diff[31:0];
          state_q <= S_EXP_C;
        end
        S_EXP_C: begin
          hsum_q <= hsum_q + e_v;
          if (b_q == nb_q - 1'b1) begin b_q <= '0; state_q <= S_DIV_A; end
          else begin b_q <= b_q + 1'b1; state_q <= S_EXP_A; end
        end
        S_DIV_A: state_q <= S_DIV_B;
        S_DIV_B: state_q <= S_DIV_W;
        S_DIV_W: if (dv_done) begin
          if (b_q == nb_q - 1'b1) begin
            b_q <= '0;
            if (h_q == hn_q - 1'b1) begin
              h_q <= '0; k_q <= '0; kk_q <= '0; hk_q <= '0; state_q <= S_WS_A;
            end else begin h_q <= h_q + 1'b1; state_q <= S_DOT_A; end
          end else begin b_q <= b_q + 1'b1; state_q <= S_DIV_A; end
        end
        S_WS_A: state_q <= S_WS_B;
        S_WS_B: begin
          if (k_q == dim_q - 1'b1) begin
            k_q <= '0; kk_q <= '0; h_q <= '0; hk_q <= '0;
            if (b_q == nb_q - 1'b1) begin b_q <= '0; state_q <= S_OUT_A; end
            else b_q <= b_q + 1'b1;
          end else begin
            k_q <= k_q + 1'b1; kk_q <= kk_q + 1'b1;
            if (hk_q == hd_q - 1'b1) begin
              hk_q <= '0; h_q <= h_q + 1'b1;
            end else hk_q <= hk_q + 1'b1;
          end
          if (!(k_q == dim_q - 1'b1 && b_q == nb_q - 1'b1)) state_q <= S_WS_A;
        end
        S_OUT_A: state_q <= S_OUT_B;
        S_OUT_B: state_q <= S_EMIT;
        S_EMIT: if (!ob_full_q || m_axis_tready) begin
          ob_val_q <= err_q ? 16'd0 :
                      (rnd > 41'sd32767) ? 16'h7fff :
                      (rnd < -41'sd32768) ? 16'h8000 : rnd[15:0];
          ob_err_q <= err_q;
          ob_last_q <= (k_q == dim_q - 1'b1);
          if (k_q == dim_q - 1'b1) begin k_q <= '0; state_q <= S_LOAD; end
          else begin k_q <= k_q + 1'b1; state_q <= err_q ? S_EMIT : S_OUT_A; end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== sv/mhsq_div.sv =====
// restoring divider, one quotient bit per cycle
module mhsq_div
  import mhsq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [47:0] quot_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [47:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] trial;

  always_comb begin
    cnt_d = cnt_q;
    busy_d = busy_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    done_o = 1'b0;
    trial = {rem_q[31:0], quo_q[47]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = 6'd0;
      quo_d = req_i.num;
      rem_d = '0;
      den_d = req_i.den;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  // final quotient is valid while done_o is high
  assign quot_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end
endmodule

// ===== sim/testbench.sv =====
// testbench for the single query multi head attention block
`timescale 1ns / 100ps

module testbench;
  import mhsq_pkg::*;

  localparam int unsigned WatchdogLimit = 400000;

  typedef struct {
    logic [15:0] value;
    logic        last;
    logic        err;
  } attn_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // predictor copy of the registers
  logic [6:0]  dim_reg = 7'd64;
  logic [3:0]  heads_reg = 4'd1;
  logic [4:0]  blocks_reg = 5'd16;
  logic [3:0]  query_reg = 4'd0;
  logic [15:0] scale_reg = 16'd8192;

  logic signed [15:0] job_elems [1024];
  int unsigned        elems_loaded = 0;
  attn_out_t          expected_outputs [$];

  int unsigned mismatches = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned idle_cycles = 0;

  multihead_attention_single_query DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // elem_value
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // out_value
    .m_axis_tlast  (m_axis_tlast),   // out_last
    .m_axis_tuser  (m_axis_tuser)    // error
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  function automatic int unsigned exp_neg2(longint x);
    longint unsigned y;
    int unsigned     n, i, r, m;
    if (x < 0) x = 0;
    if (x > (64'sd1 <<< 36)) return 0;
    y = (longint'(x) * 94548) >> 16;
    n = int'(y >> 16);
    if (n > 16) return 0;
    i = int'((y >> 12) & 15);
    r = int'(y & 4095);
    m = pow2_tab(5'(i)) - (((pow2_tab(5'(i)) - pow2_tab(5'(i + 1))) * r) >> 12);
    return m >> n;
  endfunction

  task automatic predict_attention_job(int unsigned dim, int unsigned nb, int unsigned q);
    longint      score [16][8];
    longint      hsum [8];
    longint      acc [64];
    longint      dot, s, mx, r;
    int unsigned hd;
    bit          bad;
    bad = heads_reg == 0 || heads_reg > 8 || (dim % heads_reg) != 0;
    foreach (acc[k]) acc[k] = 0;
    if (!bad) begin
      hd = dim / heads_reg;
      for (int h = 0; h < heads_reg; h++) begin
        mx = -64'sd2147483648;
        hsum[h] = 0;
        for (int b = 0; b < nb; b++) begin
          dot = 0;
          for (int k = h * hd; k < (h + 1) * hd; k++)
            dot += longint'(job_elems[b * dim + k]) * longint'(job_elems[q * dim + k]);
          s = (dot * longint'(scale_reg)) >>> 16;
          if (s > 64'sd2147483647) s = 64'sd2147483647;
          if (s < -64'sd2147483648) s = -64'sd2147483648;
          score[b][h] = s;
          if (s > mx) mx = s;
        end
        for (int b = 0; b < nb; b++) begin
          score[b][h] = exp_neg2(mx - score[b][h]);
          hsum[h] += score[b][h];
        end
        for (int b = 0; b < nb; b++)
          score[b][h] = hsum[h] != 0 ? (score[b][h] <<< 16) / hsum[h] : 0;
      end
      for (int b = 0; b < nb; b++)
        for (int k = 0; k < dim; k++)
          acc[k] += score[b][k / hd] * longint'(job_elems[b * dim + k]);
    end
    for (int k = 0; k < dim; k++) begin
      attn_out_t o;
      r = bad ? 0 : (acc[k] + 32768) >>> 16;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      o.value = r[15:0];
      o.last = (k == dim - 1);
      o.err = bad;
      expected_outputs.push_back(o);
    end
  endtask

  task automatic accept_elem(logic [15:0] v);
    int unsigned dim, nb, q;
    dim = dim_reg < 1 ? 1 : (dim_reg > 64 ? 64 : dim_reg);
    nb = blocks_reg < 1 ? 1 : (blocks_reg > 16 ? 16 : blocks_reg);
    q = query_reg >= nb ? nb - 1 : query_reg;
    if (elems_loaded < 1024) job_elems[elems_loaded] = v;
    elems_loaded++;
    if (elems_loaded >= nb * dim) begin
      elems_loaded = 0;
      predict_attention_job(dim, nb, q);
    end
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_outputs.size() == 0) begin
        report_mismatch("unexpected output", m_axis_tdata, 16'h0);
      end else begin
        attn_out_t e;
        e = expected_outputs.pop_front();
        if (m_axis_tdata !== e.value) report_mismatch("out_value", m_axis_tdata, e.value);
        if (m_axis_tlast !== e.last)
          report_mismatch("out_last", 16'(m_axis_tlast), 16'(e.last));
        if (m_axis_tuser !== e.err)
          report_mismatch("error", 16'(m_axis_tuser), 16'(e.err));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
        $display("[multihead_attention_single_query] ERROR");
        $finish;
      end
    end
  end

  task automatic send_elem(logic [15:0] v);
    @(negedge clk_i);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    accept_elem(v);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegDim:   dim_reg = val[6:0];
      RegHeads: heads_reg = val[3:0];
      RegBlks:  blocks_reg = val[4:0];
      RegQuery: query_reg = val[3:0];
      RegScale: scale_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_job(int dim, int heads, int nb, int q, int scale);
    write_reg(RegDim, 16'(dim));
    write_reg(RegHeads, 16'(heads));
    write_reg(RegBlks, 16'(nb));
    write_reg(RegQuery, 16'(q));
    write_reg(RegScale, 16'(scale));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic int unsigned job_items();
    int unsigned dim, nb;
    dim = dim_reg < 1 ? 1 : (dim_reg > 64 ? 64 : dim_reg);
    nb = blocks_reg < 1 ? 1 : (blocks_reg > 16 ? 16 : blocks_reg);
    return dim * nb;
  endfunction

  task automatic test_directed_extremes();
    logic [15:0] vals [8] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                              16'h0100, 16'h5555, 16'haaaa, 16'h0001};
    set_job(4, 2, 2, 1, 16'hffff);
    foreach (vals[i]) send_elem(vals[i]);
    wait_drained();
    // head count not dividing the vector size
    write_reg(RegHeads, 16'd3);
    foreach (vals[i]) send_elem(vals[7 - i]);
    wait_drained();
    // zero heads, zero size and blocks clamp to one, query clamps
    set_job(0, 0, 0, 15, 0);
    send_elem(16'h1234);
    wait_drained();
    set_job(1, 9, 31, 15, 8192);
    repeat (job_items()) send_elem(16'($urandom));
    wait_drained();
  endtask

  task automatic test_random_jobs(int unsigned n_items);
    int unsigned sent, dim, heads;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(19) == 0) dim = $urandom_range(127, 16);
      else dim = $urandom_range(8, 1);
      if ($urandom_range(9) == 0) heads = $urandom_range(15);
      else begin
        heads = $urandom_range(8, 1);
        while ((dim > 64 ? 64 : dim) % heads != 0) heads--;
      end
      write_reg(RegDim, 16'(dim));
      write_reg(RegHeads, 16'(heads));
      write_reg(RegBlks, 16'(dim > 8 ? $urandom_range(2, 1) : $urandom_range(31)));
      write_reg(RegQuery, 16'($urandom_range(15)));
      case ($urandom_range(3))
        0: write_reg(RegScale, 16'hffff);
        1: write_reg(RegScale, 16'h0000);
        default: write_reg(RegScale, 16'($urandom));
      endcase
      repeat (job_items()) begin
        if ($urandom_range(3) == 0) send_elem(16'($urandom));
        else send_elem(16'($signed($urandom_range(1023)) - 512));
        sent++;
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    sender_idle_pct = 7;
    receiver_idle_pct = 58;
    test_directed_extremes();
    test_random_jobs(75);
    sender_idle_pct = 58;
    receiver_idle_pct = 7;
    test_random_jobs(75);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_jobs(75);
    wait_drained();
    if (mismatches == 0) begin
      $display("[multihead_attention_single_query] OK");
    end else begin
      $display("[multihead_attention_single_query] ERROR");
    end
    $finish;
  end
endmodule
